// ===== sv/csmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types and constants for the CSR sparse matrix-vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csmv_pkg;

	// input word kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_NONZERO = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;

	// widest vector index carried between front and back
	localparam int unsigned IDX_W = 8;

	// decoupling queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         position;
		logic signed [15:0] element_value;
		logic               row_end;
	} item_word_t;

	typedef struct packed {
		logic [15:0]        row_index;
		logic signed [15:0] row_sum;
	} result_word_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_EMPTY
	} op_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic signed [15:0] value;
		logic               last;
	} op_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== sv/csmv_front.sv =====
// ----------------------------------------------------------------------------
// csmv_front
// Accepts input words, reduces the index modulo the vector depth and turns
// each word of a known kind into an operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csmv_front #(
	parameter int unsigned VEC_DEPTH = 256
) (
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire csmv_pkg::item_word_t    item,
	input  wire csmv_pkg::queue_status_t q_status,
	output logic                        push,
	output csmv_pkg::op_word_t          push_word
);

	logic [csmv_pkg::IDX_W-1:0] idx_tbl [256];

	// index reduction table, worked out at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_idx
		assign idx_tbl[g] = csmv_pkg::IDX_W'(g % VEC_DEPTH);
	end

	assign item_stall = q_status.full;

	always_comb begin
		push_word.idx   = idx_tbl[item.position];
		push_word.value = item.element_value;
		push_word.last  = item.row_end;
		push_word.op    = csmv_pkg::OP_LOAD;
		push            = 1'b0;
		case (item.kind)
			csmv_pkg::KIND_LOAD: begin
				push_word.op = csmv_pkg::OP_LOAD;
				push         = item_valid && !q_status.full;
			end
			csmv_pkg::KIND_NONZERO: begin
				push_word.op = csmv_pkg::OP_MAC;
				push         = item_valid && !q_status.full;
			end
			csmv_pkg::KIND_EMPTY: begin
				push_word.op = csmv_pkg::OP_EMPTY;
				push         = item_valid && !q_status.full;
			end
			default: begin
				// unused kind is dropped
				push = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/csmv_queue.sv =====
// ----------------------------------------------------------------------------
// csmv_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module csmv_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire csmv_pkg::op_word_t    push_word,
	input  wire logic                 pop,
	output csmv_pkg::op_word_t        head,
	output csmv_pkg::queue_status_t   status
);

	csmv_pkg::op_word_t             slot_q [csmv_pkg::QUEUE_DEPTH];
	logic [csmv_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [csmv_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [csmv_pkg::QCNT_W-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign status.full  = (count_q == csmv_pkg::QCNT_W'(csmv_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

`default_nettype wire

// ===== sv/csmv_back.sv =====
// ----------------------------------------------------------------------------
// csmv_back
// Vector store, multiply, scale and row accumulation, with the result
// register in front of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csmv_back #(
	parameter int unsigned VEC_DEPTH = 256,
	parameter int unsigned FRAC_BITS = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire csmv_pkg::op_word_t      head,
	input  wire csmv_pkg::queue_status_t q_status,
	output logic                        pop,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output csmv_pkg::result_word_t      result
);

	// only the first 256 entries can ever be addressed
	localparam int unsigned STORE_DEPTH = (VEC_DEPTH < 256) ? VEC_DEPTH : 256;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

	logic signed [15:0]  store [STORE_DEPTH];
	logic [ADDR_W-1:0]   addr;
	logic                adv;

	logic                valid_s1;
	csmv_pkg::op_t       op_s1;
	logic signed [15:0]  weight_s1;
	logic signed [15:0]  vec_s1;
	logic                last_s1;

	logic                valid_s2;
	csmv_pkg::op_t       op_s2;
	logic signed [31:0]  prod_s2;
	logic                last_s2;

	logic [15:0]         acc_q;
	logic [15:0]         row_cnt_q;
	logic                out_valid_q;
	csmv_pkg::result_word_t result_q;

	logic signed [31:0]  prod_shift;
	logic [15:0]         sum;
	logic [15:0]         acc_d;
	logic [15:0]         row_cnt_d;
	logic                out_valid_d;
	csmv_pkg::result_word_t result_d;

	// whole back end moves when the result register is free
	assign adv          = !out_valid_q || !result_stall;
	assign pop          = adv && !q_status.empty;
	assign addr         = head.idx[ADDR_W-1:0];
	assign result_valid = out_valid_q;
	assign result       = result_q;

	// stage 1: vector store access, write for loads and registered read
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.op == csmv_pkg::OP_LOAD) begin
				store[addr] <= head.value;
			end
			vec_s1 <= store[addr];
		end
		if (adv) begin
			op_s1     <= head.op;
			weight_s1 <= head.value;
			last_s1   <= head.last;
		end
	end

	// stage 2: product
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			prod_s2 <= weight_s1 * vec_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
		end
	end

	// stage 3: scale, accumulate and emit
	assign prod_shift = prod_s2 >>> FRAC_BITS;
	assign sum        = acc_q + prod_shift[15:0];

	always_comb begin
		acc_d       = acc_q;
		row_cnt_d   = row_cnt_q;
		out_valid_d = 1'b0;
		result_d.row_index = row_cnt_q;
		result_d.row_sum   = '0;
		if (valid_s2) begin
			case (op_s2)
				csmv_pkg::OP_LOAD: begin
					acc_d     = '0;
					row_cnt_d = '0;
				end
				csmv_pkg::OP_MAC: begin
					if (last_s2) begin
						result_d.row_sum = sum;
						out_valid_d      = 1'b1;
						acc_d            = '0;
						row_cnt_d        = row_cnt_q + 1'b1;
					end else begin
						acc_d = sum;
					end
				end
				csmv_pkg::OP_EMPTY: begin
					out_valid_d = 1'b1;
					row_cnt_d   = row_cnt_q + 1'b1;
				end
				default: begin
					acc_d = acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			acc_q       <= acc_d;
			row_cnt_q   <= row_cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/csr_sparse_matvec_fixed_unit.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matvec_fixed_unit
// Sparse matrix times dense vector, matrix streamed in compressed row form,
// 16-bit fixed-point values with wrapping row sums.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle while its queue is not full and, while
// the result side keeps up, returns one result per cycle for every row-end
// or empty-row word. A word passes a four-entry queue and three back-end
// stages (vector store read, multiply, scale and accumulate into the
// result register); the single multiply-accumulate and the result register
// set the rate of one word a cycle while the result side keeps up. Load
// words write the vector store and restart the row count; a nonzero must
// only use vector entries loaded since reset. Indexes are reduced modulo
// VEC_DEPTH. The vector store is not cleared at reset.
`default_nettype none

module csr_sparse_matvec_fixed_unit #(
	parameter int unsigned VEC_DEPTH = 256,
	parameter int unsigned FRAC_BITS = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire csmv_pkg::item_word_t   item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output csmv_pkg::result_word_t     result
);

	csmv_pkg::queue_status_t q_status;
	csmv_pkg::op_word_t      push_word;
	csmv_pkg::op_word_t      head;
	logic                    push;
	logic                    pop;

	csmv_front #(
		.VEC_DEPTH (VEC_DEPTH)
	) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_word  (push_word)
	);

	csmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	csmv_back #(
		.VEC_DEPTH (VEC_DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== sv/csmv_checker.sv =====
// ----------------------------------------------------------------------------
// csmv_port_checks
// Port-level checks for the sparse matrix-vector unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module csmv_port_checks (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   item_valid,
	input wire logic                   item_stall,
	input wire csmv_pkg::item_word_t    item,
	input wire logic                   result_valid,
	input wire logic                   result_stall,
	input wire csmv_pkg::result_word_t  result
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// a cycle with the result side free drains the queue below full
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |=> !item_stall)
		else $error("input stalled although results were draining");

	// nothing pending right out of reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid && !item_stall)
		else $error("unit not empty after reset");

	// a word passes the queue and the back-end stage registers before it reaches the result register
	assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid [*3])
		else $error("result word appeared too early after reset");

endmodule

bind csr_sparse_matvec_fixed_unit csmv_port_checks u_csmv_port_checks (.*);

`default_nettype wire
